// ===== rtl/dmp_pkg.sv =====
// Package with types, constants and the header field map of the DHCP message parser.
`timescale 1ns / 1ps
package dmp_pkg;

  localparam logic [7:0] HDR_LEN   = 8'd240;
  localparam logic [7:0] CHADDR_AT = 8'd28;
  localparam logic [7:0] SNAME_AT  = 8'd44;
  localparam logic [7:0] FILE_AT   = 8'd108;
  localparam logic [7:0] COOKIE_AT = 8'd236;
  localparam logic [7:0] HWLEN_AT  = 8'd2;
  localparam logic [4:0] HW_CAP    = 5'd16;
  localparam logic [7:0] END_CODE  = 8'hFF;
  localparam logic [7:0] PAD_CODE  = 8'h00;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_FIELD  = 3'd0,
    KIND_HWADDR = 3'd1,
    KIND_SNAME  = 3'd2,
    KIND_FILE   = 3'd3,
    KIND_OPTHDR = 3'd4,
    KIND_OPTDAT = 3'd5,
    KIND_END    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HDR_TRUNC = 2'd1,
    ST_OPT_TRUNC = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    FLD_MSGTYPE = 4'd0,
    FLD_HWTYPE  = 4'd1,
    FLD_HWLEN   = 4'd2,
    FLD_HOPS    = 4'd3,
    FLD_XID     = 4'd4,
    FLD_SECS    = 4'd5,
    FLD_FLAGS   = 4'd6,
    FLD_CIADDR  = 4'd7,
    FLD_YIADDR  = 4'd8,
    FLD_SIADDR  = 4'd9,
    FLD_GIADDR  = 4'd10,
    FLD_COOKIE  = 4'd11
  } field_e;

  typedef struct packed {
    field_e     id;
    logic [7:0] start;
    logic [1:0] last_idx;
  } hfield_t;

  typedef struct packed {
    kind_e      kind;
    field_e     field_id;
    logic [31:0] field_value;
    logic [7:0] option_code;
    logic [7:0] option_size;
    logic [7:0] byte_index;
    logic       option_final;
    logic       packet_end;
    status_e    status;
  } out_item_t;

  function automatic hfield_t field_lookup(input logic [7:0] off);
    hfield_t f;
    f = '{id: FLD_MSGTYPE, start: 8'd0, last_idx: 2'd0};
    case (off) inside
      8'd0:             f = '{id: FLD_MSGTYPE, start: 8'd0,   last_idx: 2'd0};
      8'd1:             f = '{id: FLD_HWTYPE,  start: 8'd1,   last_idx: 2'd0};
      8'd2:             f = '{id: FLD_HWLEN,   start: 8'd2,   last_idx: 2'd0};
      8'd3:             f = '{id: FLD_HOPS,    start: 8'd3,   last_idx: 2'd0};
      [8'd4:8'd7]:      f = '{id: FLD_XID,     start: 8'd4,   last_idx: 2'd3};
      [8'd8:8'd9]:      f = '{id: FLD_SECS,    start: 8'd8,   last_idx: 2'd1};
      [8'd10:8'd11]:    f = '{id: FLD_FLAGS,   start: 8'd10,  last_idx: 2'd1};
      [8'd12:8'd15]:    f = '{id: FLD_CIADDR,  start: 8'd12,  last_idx: 2'd3};
      [8'd16:8'd19]:    f = '{id: FLD_YIADDR,  start: 8'd16,  last_idx: 2'd3};
      [8'd20:8'd23]:    f = '{id: FLD_SIADDR,  start: 8'd20,  last_idx: 2'd3};
      [8'd24:8'd27]:    f = '{id: FLD_GIADDR,  start: 8'd24,  last_idx: 2'd3};
      [8'd236:8'd239]:  f = '{id: FLD_COOKIE,  start: 8'd236, last_idx: 2'd3};
      default:          f = '{id: FLD_MSGTYPE, start: 8'd0,   last_idx: 2'd0};
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/dmp_in_if.sv =====
// Byte stream channel carrying DHCP payload bytes into the parser.
`timescale 1ns / 1ps
interface dmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_last;

  modport source (output valid, output data_byte, output packet_last, input ready);
  modport sink   (input valid, input data_byte, input packet_last, output ready);
endinterface

// ===== rtl/dmp_out_if.sv =====
// Result channel carrying parsed DHCP fields out of the parser.
`timescale 1ns / 1ps
interface dmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  field_id;
  logic [31:0] field_value;
  logic [7:0]  option_code;
  logic [7:0]  option_size;
  logic [7:0]  byte_index;
  logic        option_final;
  logic        packet_end;
  logic [1:0]  status;

  modport source (output valid, output kind, output field_id, output field_value,
                  output option_code, output option_size, output byte_index,
                  output option_final, output packet_end, output status, input ready);
  modport sink   (input valid, input kind, input field_id, input field_value,
                  input option_code, input option_size, input byte_index,
                  input option_final, input packet_end, input status, output ready);
endinterface

// ===== rtl/dhcp_message_parser_top.sv =====
// DHCP message parser top level: byte walker over header and options with a result register.
// A byte that yields a result has it loaded into the output register on the edge that accepts the byte.
// Throughput: one byte per cycle; the parse state and the result register advance together.
// A byte is taken whenever the result register is empty or being drained in the same cycle.
// Reset (asynchronous, active low) empties the result register and returns the walker
// to the start of the header; the walker also returns there after every final byte.
`timescale 1ns / 1ps
module dhcp_message_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  dmp_in_if.sink       in_i,
  dmp_out_if.source    out_o
);
  import dmp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_off_q, hdr_off_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  hwlen_q, hwlen_d;
  logic        name_q, name_d;
  logic        file_q, file_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  size_q, size_d;
  logic [7:0]  count_q, count_d;

  out_item_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic        res_vld;

  logic        in_acc;
  logic [7:0]  b;
  hfield_t     fld;
  logic [31:0] acc_base;
  logic [7:0]  area_idx;
  logic [7:0]  count_inc;
  logic [8:0]  off_inc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign fld        = field_lookup(hdr_off_q);
  assign acc_base   = (hdr_off_q == fld.start) ? 32'd0 : acc_q;
  assign count_inc  = count_q + 8'd1;
  assign off_inc    = {1'b0, hdr_off_q} + 9'd1;

  always_comb begin
    phase_d   = phase_q;
    hdr_off_d = hdr_off_q;
    acc_d     = acc_q;
    hwlen_d   = hwlen_q;
    name_d    = name_q;
    file_d    = file_q;
    code_d    = code_q;
    size_d    = size_q;
    count_d   = count_q;
    res_d     = '{kind: KIND_FIELD, field_id: FLD_MSGTYPE, status: ST_OK, default: '0};
    res_vld   = 1'b0;
    area_idx  = 8'd0;

    case (phase_q)
      PH_HEADER: begin
        if (hdr_off_q < CHADDR_AT || hdr_off_q >= COOKIE_AT) begin
          if (fld.id == FLD_SECS) begin
            acc_d = {16'd0, b, acc_base[15:8]};
          end else begin
            acc_d = {acc_base[23:0], b};
          end
          if (hdr_off_q == HWLEN_AT) begin
            hwlen_d = (b > {3'd0, HW_CAP}) ? HW_CAP : b[4:0];
          end
          if (hdr_off_q == fld.start + {6'd0, fld.last_idx}) begin
            res_vld           = 1'b1;
            res_d.kind        = KIND_FIELD;
            res_d.field_id    = fld.id;
            res_d.field_value = acc_d;
            res_d.byte_index  = {6'd0, fld.last_idx};
          end
        end else if (hdr_off_q < SNAME_AT) begin
          area_idx = hdr_off_q - CHADDR_AT;
          if (area_idx < {3'd0, hwlen_q}) begin
            res_vld           = 1'b1;
            res_d.kind        = KIND_HWADDR;
            res_d.field_value = {24'd0, b};
            res_d.byte_index  = area_idx;
          end
        end else if (hdr_off_q < FILE_AT) begin
          area_idx = hdr_off_q - SNAME_AT;
          if (area_idx == 8'd0) begin
            name_d = (b != 8'd0);
          end
          if (name_d) begin
            res_vld           = 1'b1;
            res_d.kind        = KIND_SNAME;
            res_d.field_value = {24'd0, b};
            res_d.byte_index  = area_idx;
          end
        end else begin
          area_idx = hdr_off_q - FILE_AT;
          if (area_idx == 8'd0) begin
            file_d = (b != 8'd0);
          end
          if (file_d) begin
            res_vld           = 1'b1;
            res_d.kind        = KIND_FILE;
            res_d.field_value = {24'd0, b};
            res_d.byte_index  = area_idx;
          end
        end
        if (off_inc >= {1'b0, HDR_LEN}) begin
          hdr_off_d = HDR_LEN;
          phase_d   = PH_CODE;
        end else begin
          hdr_off_d = off_inc[7:0];
        end
        if (in_i.packet_last && phase_d == PH_HEADER) begin
          res_d.status = ST_HDR_TRUNC;
        end
      end
      PH_CODE: begin
        if (b == END_CODE) begin
          phase_d = PH_DONE;
        end else if (b != PAD_CODE) begin
          code_d  = b;
          phase_d = PH_LEN;
          if (in_i.packet_last) begin
            res_d.status = ST_OPT_TRUNC;
          end
        end
      end
      PH_LEN: begin
        size_d            = b;
        count_d           = 8'd0;
        res_vld           = 1'b1;
        res_d.kind        = KIND_OPTHDR;
        res_d.option_code = code_q;
        res_d.option_size = b;
        if (b == 8'd0) begin
          res_d.option_final = 1'b1;
          phase_d            = PH_CODE;
        end else begin
          phase_d = PH_DATA;
          if (in_i.packet_last) begin
            res_d.status = ST_OPT_TRUNC;
          end
        end
      end
      PH_DATA: begin
        res_vld           = 1'b1;
        res_d.kind        = KIND_OPTDAT;
        res_d.field_value = {24'd0, b};
        res_d.option_code = code_q;
        res_d.option_size = size_q;
        res_d.byte_index  = count_q;
        count_d           = count_inc;
        if (count_inc >= size_q) begin
          res_d.option_final = 1'b1;
          phase_d            = PH_CODE;
        end else if (in_i.packet_last) begin
          res_d.status = ST_OPT_TRUNC;
        end
      end
      default: begin
      end
    endcase

    if (in_i.packet_last) begin
      if (!res_vld) begin
        res_d = '{kind: KIND_END, field_id: FLD_MSGTYPE, status: res_d.status, default: '0};
      end
      res_vld          = 1'b1;
      res_d.packet_end = 1'b1;
      phase_d          = PH_HEADER;
      hdr_off_d        = 8'd0;
      acc_d            = 32'd0;
      hwlen_d          = 5'd0;
      name_d           = 1'b0;
      file_d           = 1'b0;
      code_d           = 8'd0;
      size_d           = 8'd0;
      count_d          = 8'd0;
    end
  end

  always_comb begin
    if (in_acc && res_vld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_off_q   <= 8'd0;
      acc_q       <= 32'd0;
      hwlen_q     <= 5'd0;
      name_q      <= 1'b0;
      file_q      <= 1'b0;
      code_q      <= 8'd0;
      size_q      <= 8'd0;
      count_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q   <= phase_d;
        hdr_off_q <= hdr_off_d;
        acc_q     <= acc_d;
        hwlen_q   <= hwlen_d;
        name_q    <= name_d;
        file_q    <= file_d;
        code_q    <= code_d;
        size_q    <= size_d;
        count_q   <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_vld) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.field_id     = res_q.field_id;
  assign out_o.field_value  = res_q.field_value;
  assign out_o.option_code  = res_q.option_code;
  assign out_o.option_size  = res_q.option_size;
  assign out_o.byte_index   = res_q.byte_index;
  assign out_o.option_final = res_q.option_final;
  assign out_o.packet_end   = res_q.packet_end;
  assign out_o.status       = res_q.status;

`ifndef SYNTHESIS
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status != ST_OK |-> res_q.packet_end)
    else $error("nonzero status without packet end");

  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KIND_END |-> res_q.packet_end)
    else $error("end-only result without packet end");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.packet_last |=> phase_q == PH_HEADER && hdr_off_q == 8'd0)
    else $error("parser not restarted after final byte");

  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> hdr_off_q < HDR_LEN)
    else $error("header offset out of range in header phase");

  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.packet_last |=> out_valid_q && res_q.packet_end)
    else $error("final byte produced no result");
`endif

endmodule

// ===== tb/sv/tb_dhcp_message_parser_top.sv =====
// Self-checking testbench for the DHCP message parser with a byte-walk predictor.
`timescale 1ns / 1ps
module tb_dhcp_message_parser_top;
  import dmp_pkg::*;

  localparam int RANDOM_BYTES = 1400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic       drain_mark;
    logic [7:0] data;
    logic       is_last;
  } feed_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dmp_in_if  in_if ();
  dmp_out_if out_if ();

  dhcp_message_parser_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  feed_t       byte_feed[$];
  out_item_t   parsed_due[$];
  logic [7:0]  pkt_bytes[$];
  int unsigned mismatches  = 0;
  int unsigned idle_run    = 0;
  int unsigned fields_seen = 0;
  logic        in_taken    = 1'b0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          hold_left   = 0;
  int          hold_stage  = 0;
  int          ready_mode  = 0;
  logic [31:0] ready_mask  = '1;
  int unsigned rx_cycle    = 0;

  logic [7:0]  hdr_pos;
  logic [31:0] fld_acc;
  logic [4:0]  hw_len;
  logic        sname_on;
  logic        file_on;
  phase_e      walk_phase;
  logic [7:0]  opt_code;
  logic [7:0]  opt_len;
  logic [7:0]  opt_count;

  function automatic void clear_walk();
    hdr_pos    = '0;
    fld_acc    = '0;
    hw_len     = '0;
    sname_on   = 1'b0;
    file_on    = 1'b0;
    walk_phase = PH_HEADER;
    opt_code   = '0;
    opt_len    = '0;
    opt_count  = '0;
  endfunction

  // {start offset, length} of each fixed header field
  function automatic logic [15:0] field_span(input field_e id);
    case (id)
      FLD_MSGTYPE: return {8'd0, 8'd1};
      FLD_HWTYPE:  return {8'd1, 8'd1};
      FLD_HWLEN:   return {8'd2, 8'd1};
      FLD_HOPS:    return {8'd3, 8'd1};
      FLD_XID:     return {8'd4, 8'd4};
      FLD_SECS:    return {8'd8, 8'd2};
      FLD_FLAGS:   return {8'd10, 8'd2};
      FLD_CIADDR:  return {8'd12, 8'd4};
      FLD_YIADDR:  return {8'd16, 8'd4};
      FLD_SIADDR:  return {8'd20, 8'd4};
      FLD_GIADDR:  return {8'd24, 8'd4};
      FLD_COOKIE:  return {COOKIE_AT, 8'd4};
      default:     return '0;
    endcase
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                    output out_item_t r);
    bit          hit;
    status_e     st;
    int unsigned o;
    int unsigned f;
    int unsigned i;
    int unsigned k;
    logic [15:0] span;
    hit = 1'b0;
    st  = ST_OK;
    r   = '0;
    case (walk_phase)
      PH_HEADER: begin
        o = {24'd0, hdr_pos};
        if (o < CHADDR_AT || o >= COOKIE_AT) begin
          f = 0;
          for (k = 0; k < 12; k++) begin
            span = field_span(field_e'(k));
            if (o >= span[15:8] && o < span[15:8] + span[7:0]) f = k;
          end
          span = field_span(field_e'(f));
          if (o == span[15:8]) fld_acc = '0;
          if (field_e'(f) == FLD_SECS) fld_acc = {16'h0, b, fld_acc[15:8]};
          else fld_acc = {fld_acc[23:0], b};
          if (o == HWLEN_AT) hw_len = (b > HW_CAP) ? HW_CAP : b[4:0];
          if (o == span[15:8] + span[7:0] - 1) begin
            hit           = 1'b1;
            r.kind        = KIND_FIELD;
            r.field_id    = field_e'(f);
            r.field_value = fld_acc;
            r.byte_index  = span[7:0] - 8'd1;
          end
        end else if (o < SNAME_AT) begin
          i = o - CHADDR_AT;
          if (i < hw_len) begin
            hit           = 1'b1;
            r.kind        = KIND_HWADDR;
            r.field_value = {24'd0, b};
            r.byte_index  = i[7:0];
          end
        end else if (o < FILE_AT) begin
          i = o - SNAME_AT;
          if (i == 0) sname_on = (b != 8'h00);
          if (sname_on) begin
            hit           = 1'b1;
            r.kind        = KIND_SNAME;
            r.field_value = {24'd0, b};
            r.byte_index  = i[7:0];
          end
        end else begin
          i = o - FILE_AT;
          if (i == 0) file_on = (b != 8'h00);
          if (file_on) begin
            hit           = 1'b1;
            r.kind        = KIND_FILE;
            r.field_value = {24'd0, b};
            r.byte_index  = i[7:0];
          end
        end
        if (o + 1 >= HDR_LEN) begin
          hdr_pos    = HDR_LEN;
          walk_phase = PH_CODE;
        end else begin
          hdr_pos = 8'(o + 1);
        end
        if (is_last && walk_phase == PH_HEADER) st = ST_HDR_TRUNC;
      end
      PH_CODE: begin
        if (b == END_CODE) begin
          walk_phase = PH_DONE;
        end else if (b != PAD_CODE) begin
          opt_code   = b;
          walk_phase = PH_LEN;
          if (is_last) st = ST_OPT_TRUNC;
        end
      end
      PH_LEN: begin
        opt_len       = b;
        opt_count     = '0;
        hit           = 1'b1;
        r.kind        = KIND_OPTHDR;
        r.option_code = opt_code;
        r.option_size = opt_len;
        if (b == 8'h00) begin
          r.option_final = 1'b1;
          walk_phase     = PH_CODE;
        end else begin
          walk_phase = PH_DATA;
          if (is_last) st = ST_OPT_TRUNC;
        end
      end
      PH_DATA: begin
        hit           = 1'b1;
        r.kind        = KIND_OPTDAT;
        r.field_value = {24'd0, b};
        r.option_code = opt_code;
        r.option_size = opt_len;
        r.byte_index  = opt_count;
        opt_count     = opt_count + 8'd1;
        if (opt_count >= opt_len) begin
          r.option_final = 1'b1;
          walk_phase     = PH_CODE;
        end else if (is_last) begin
          st = ST_OPT_TRUNC;
        end
      end
      default: ;
    endcase
    if (is_last) begin
      if (!hit) begin
        r      = '0;
        r.kind = KIND_END;
        hit    = 1'b1;
      end
      r.packet_end = 1'b1;
      r.status     = st;
      clear_walk();
    end
    return hit;
  endfunction

  function automatic string item_text(input out_item_t x);
    return $sformatf("kind %0d id %0d value %h code %h size %h idx %0d fin %b end %b st %0d",
                     x.kind, x.field_id, x.field_value, x.option_code, x.option_size,
                     x.byte_index, x.option_final, x.packet_end, x.status);
  endfunction

  always @(posedge clk_i) begin : monitor
    out_item_t got;
    out_item_t due;
    logic      out_taken;
    in_taken  = in_if.valid && in_if.ready;
    out_taken = out_if.valid && out_if.ready;
    idle_run  = (in_taken || out_taken) ? 0 : idle_run + 1;
    if (out_taken) begin
      got = '{kind: kind_e'(out_if.kind), field_id: field_e'(out_if.field_id),
              field_value: out_if.field_value, option_code: out_if.option_code,
              option_size: out_if.option_size, byte_index: out_if.byte_index,
              option_final: out_if.option_final, packet_end: out_if.packet_end,
              status: status_e'(out_if.status)};
      fields_seen++;
      if (parsed_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result at %0t ns: %s", $time, item_text(got));
        mismatches++;
      end else begin
        due = parsed_due.pop_front();
        if (got.kind !== due.kind || got.field_id !== due.field_id ||
            got.field_value !== due.field_value || got.option_code !== due.option_code ||
            got.option_size !== due.option_size || got.byte_index !== due.byte_index ||
            got.option_final !== due.option_final || got.packet_end !== due.packet_end ||
            got.status !== due.status) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t ns\n  expected %s\n  actual   %s",
                     $time, item_text(due), item_text(got));
          mismatches++;
        end
      end
    end
    if (in_taken) begin
      if (parse_byte(in_if.data_byte, in_if.packet_last, due)) parsed_due.push_back(due);
    end
  end

  always @(negedge clk_i) begin : driver
    feed_t      nxt;
    logic       v;
    logic [7:0] d;
    logic       l;
    v = in_if.valid;
    d = in_if.data_byte;
    l = in_if.packet_last;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_feed.size() > 0) begin
        if (byte_feed[0].drain_mark) begin
          if (parsed_due.size() == 0) void'(byte_feed.pop_front());
        end else begin
          nxt = byte_feed.pop_front();
          v   = 1'b1;
          d   = nxt.data;
          l   = nxt.is_last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    in_if.valid       <= v;
    in_if.data_byte   <= d;
    in_if.packet_last <= l;
  end

  always @(negedge clk_i) begin : receiver
    logic       r;
    logic [4:0] slot;
    logic [4:0] slot_b;
    r = 1'b0;
    if (rst_ni) begin
      rx_cycle++;
      slot   = rx_cycle[4:0];
      slot_b = slot + 5'd7;
      if (hold_left == 0 && ((hold_stage == 0 && fields_seen >= 100) ||
                             (hold_stage == 1 && fields_seen >= 400))) begin
        hold_stage++;
        hold_left = HOLD_CYCLES;
      end
      if (rx_cycle % 64 == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_mask = $urandom();
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        case (ready_mode)
          0:       r = 1'b1;
          1:       r = ready_mask[slot];
          2:       r = ($urandom_range(0, 3) != 0);
          default: r = ready_mask[slot] | ready_mask[slot_b];
        endcase
      end
    end
    out_if.ready <= r;
  end

  task automatic send_packet();
    feed_t fb;
    while (pkt_bytes.size() > 0) begin
      fb.drain_mark = 1'b0;
      fb.data       = pkt_bytes.pop_front();
      fb.is_last    = (pkt_bytes.size() == 0);
      byte_feed.push_back(fb);
    end
  endtask

  task automatic drain_pause();
    feed_t fb;
    fb = '{drain_mark: 1'b1, data: 8'h00, is_last: 1'b0};
    byte_feed.push_back(fb);
  endtask

  task automatic add_word(input logic [63:0] w, input int n);
    int k;
    for (k = n - 1; k >= 0; k--) pkt_bytes.push_back(8'(w >> (8 * k)));
  endtask

  task automatic add_header(input int unsigned upto);
    int unsigned o;
    logic [7:0]  b;
    logic [31:0] magic;
    bit          use_magic;
    magic     = 32'h6382_5363;
    use_magic = ($urandom_range(0, 1) == 1);
    for (o = 0; o < upto; o++) begin
      b = 8'($urandom_range(0, 255));
      if (o == HWLEN_AT) begin
        case ($urandom_range(0, 3))
          0:       b = 8'($urandom_range(17, 255));
          1:       b = 8'd16;
          default: b = 8'($urandom_range(0, 15));
        endcase
      end
      if ((o == SNAME_AT || o == FILE_AT) && $urandom_range(0, 1)) b = 8'h00;
      if (o >= COOKIE_AT && use_magic) b = 8'(magic >> (8 * (HDR_LEN - 1 - o)));
      pkt_bytes.push_back(b);
    end
  endtask

  task automatic add_option();
    int unsigned pick;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) begin
      pkt_bytes.push_back(PAD_CODE);
    end else begin
      pick = $urandom_range(0, 49);
      if (pick < 8)       n = 0;
      else if (pick < 46) n = $urandom_range(1, 12);
      else if (pick < 49) n = $urandom_range(13, 64);
      else                n = $urandom_range(200, 255);
      pkt_bytes.push_back(8'($urandom_range(1, 254)));
      pkt_bytes.push_back(8'(n));
      repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned start_len;
    int unsigned pick;
    int unsigned n;
    bit          paused;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = 8'h00;
    in_if.packet_last  = 1'b0;
    out_if.ready       = 1'b0;
    clear_walk();

    add_word(64'hFF, 1);
    send_packet();
    add_word(64'h0000, 2);
    send_packet();
    add_word(64'h01FF_1180, 4);
    send_packet();
    add_word(64'h0201_0600_DEAD_BEEF, 8);
    add_word(64'h1234, 2);
    send_packet();
    add_word(64'h0101_0000_A55A, 6);
    send_packet();
    drain_pause();

    start_len = byte_feed.size();
    paused    = 1'b0;
    while (byte_feed.size() - start_len < RANDOM_BYTES) begin
      if (!paused && byte_feed.size() - start_len >= RANDOM_BYTES / 2) begin
        drain_pause();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        add_header(HDR_LEN);
        repeat ($urandom_range(0, 6)) add_option();
        pkt_bytes.push_back(END_CODE);
        repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        add_header($urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 239));
      end else if (pick < 17) begin
        add_header(HDR_LEN);
        repeat ($urandom_range(0, 3)) add_option();
        pkt_bytes.push_back(8'($urandom_range(1, 254)));
        case ($urandom_range(0, 2))
          0: ;
          1: pkt_bytes.push_back(8'($urandom_range(1, 255)));
          default: begin
            n = $urandom_range(2, 40);
            pkt_bytes.push_back(8'(n));
            repeat ($urandom_range(1, n - 1)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end else if (pick < 19) begin
        add_header(HDR_LEN);
        repeat ($urandom_range(0, 4)) add_option();
      end else begin
        repeat ($urandom_range(1, 300)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_packet();
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (byte_feed.size() != 0 || in_if.valid || parsed_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && parsed_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    while (idle_run < IDLE_LIMIT) @(negedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
